// ===== sv/lcg_combined_random_pick_unit_defines.svh =====
// Assertion macros shared by the random pick unit.
// Each macro takes a label, the clock, the active-low reset, an antecedent and a consequent.
`ifndef LCG_COMBINED_RANDOM_PICK_UNIT_DEFINES_SVH
`define LCG_COMBINED_RANDOM_PICK_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define LCGP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lcgp: same-cycle check failed");
`define LCGP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lcgp: next-cycle check failed");
`else
`define LCGP_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define LCGP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/lcgp_pkg.sv =====
`default_nettype none

package lcgp_pkg;

    localparam int unsigned DATA_W = 32;

    localparam logic [DATA_W-1:0] LCG_MUL    = 32'd1103515245;
    localparam logic [DATA_W-1:0] LCG_ADD    = 32'd12345;
    localparam logic [DATA_W-1:0] SEED_RESET = 32'd1;

    // Generator state bits that feed each slice of the assembled value.
    localparam int unsigned FIELD_LSB = 18;
    localparam int unsigned LO_W      = 10;
    localparam int unsigned MID_LSB   = LO_W;
    localparam int unsigned HI_LSB    = 2 * LO_W;
    localparam int unsigned HI_W      = DATA_W - HI_LSB;

    localparam int unsigned DIV_STEPS = DATA_W;
    localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);
    localparam logic [CNT_W-1:0] ADV_LAST = CNT_W'(2);

    localparam logic [1:0] ADV_LO  = 2'd0;
    localparam logic [1:0] ADV_MID = 2'd1;
    localparam logic [1:0] ADV_HI  = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ADV,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic       load_max;
        logic       advance;
        logic [1:0] adv_idx;
        logic       div_step;
        logic       out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic max_zero;
        logic out_free;
    } t_dp_sts;

    // One step of the generator, kept to the low 32 bits.
    function automatic logic [DATA_W-1:0] lcg_advance(input logic [DATA_W-1:0] s);
        logic [DATA_W-1:0] prod;
        prod = s * LCG_MUL;
        return prod + LCG_ADD;
    endfunction

endpackage

`default_nettype wire

// ===== sv/lcgp_dp.sv =====
`default_nettype none

module lcgp_dp (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  lcgp_pkg::t_dp_cmd                i_cmd,
    output lcgp_pkg::t_dp_sts                o_sts,
    input  wire                              i_cfg_we,
    input  wire  [lcgp_pkg::DATA_W-1:0]      i_cfg_seed,
    input  wire  [lcgp_pkg::DATA_W-1:0]      i_modulus,
    input  wire                              i_out_stall,
    output logic                             o_out_valid,
    output logic [lcgp_pkg::DATA_W-1:0]      o_value
);

    logic [lcgp_pkg::DATA_W-1:0] r_seed_state;
    logic [lcgp_pkg::DATA_W-1:0] r_max;
    logic [lcgp_pkg::DATA_W-1:0] r_dvd;
    logic [lcgp_pkg::DATA_W-1:0] r_rem;
    logic                        r_out_valid;
    logic [lcgp_pkg::DATA_W-1:0] r_out_value;

    logic [lcgp_pkg::DATA_W-1:0] w_next_state;
    logic [lcgp_pkg::DATA_W:0]   w_rem_sh;
    logic [lcgp_pkg::DATA_W:0]   w_diff;
    logic                        w_ge;
    logic [lcgp_pkg::DATA_W-1:0] n_rem;

    assign w_next_state = lcgp_pkg::lcg_advance(r_seed_state);

    // Restoring division step: only the remainder is kept.
    assign w_rem_sh = {r_rem, r_dvd[lcgp_pkg::DATA_W-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, r_max});
    assign w_diff   = w_rem_sh - {1'b0, r_max};
    assign n_rem    = w_ge ? w_diff[lcgp_pkg::DATA_W-1:0] : w_rem_sh[lcgp_pkg::DATA_W-1:0];

    assign o_sts.max_zero = (r_max == '0);
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed_state <= lcgp_pkg::SEED_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_seed_state <= i_cfg_seed;
            end else if (i_cmd.advance) begin
                r_seed_state <= w_next_state;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_max) begin
            r_max <= i_modulus;
            r_rem <= '0;
        end
        if (i_cmd.advance) begin
            case (i_cmd.adv_idx)
                lcgp_pkg::ADV_LO: begin
                    r_dvd[0 +: lcgp_pkg::LO_W] <=
                        w_next_state[lcgp_pkg::FIELD_LSB +: lcgp_pkg::LO_W];
                end
                lcgp_pkg::ADV_MID: begin
                    r_dvd[lcgp_pkg::MID_LSB +: lcgp_pkg::LO_W] <=
                        w_next_state[lcgp_pkg::FIELD_LSB +: lcgp_pkg::LO_W];
                end
                lcgp_pkg::ADV_HI: begin
                    r_dvd[lcgp_pkg::HI_LSB +: lcgp_pkg::HI_W] <=
                        w_next_state[lcgp_pkg::FIELD_LSB +: lcgp_pkg::HI_W];
                end
                default: begin
                end
            endcase
        end
        if (i_cmd.div_step) begin
            r_dvd <= {r_dvd[lcgp_pkg::DATA_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
        if (i_cmd.out_load) begin
            r_out_value <= o_sts.max_zero ? r_dvd : r_rem;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_value     = r_out_value;

endmodule

`default_nettype wire

// ===== sv/lcgp_ctrl.sv =====
`default_nettype none
`include "lcg_combined_random_pick_unit_defines.svh"

module lcgp_ctrl (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    input  lcgp_pkg::t_dp_sts  i_sts,
    output lcgp_pkg::t_dp_cmd  o_cmd,
    output logic               o_idle
);

    lcgp_pkg::t_state             r_state;
    lcgp_pkg::t_state             n_state;
    logic [lcgp_pkg::CNT_W-1:0]   r_cnt;
    logic [lcgp_pkg::CNT_W-1:0]   n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lcgp_pkg::S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_cnt          = r_cnt;
        o_cmd          = '0;
        o_cmd.adv_idx  = r_cnt[1:0];
        o_idle         = 1'b0;
        unique case (r_state)
            lcgp_pkg::S_IDLE: begin
                o_idle = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_max = 1'b1;
                    n_cnt          = '0;
                    n_state        = lcgp_pkg::S_ADV;
                end
            end
            lcgp_pkg::S_ADV: begin
                o_cmd.advance = 1'b1;
                if (r_cnt == lcgp_pkg::ADV_LAST) begin
                    n_cnt   = '0;
                    n_state = i_sts.max_zero ? lcgp_pkg::S_DONE : lcgp_pkg::S_DIV;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            lcgp_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == lcgp_pkg::DIV_LAST) begin
                    n_state = lcgp_pkg::S_DONE;
                end
            end
            lcgp_pkg::S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = lcgp_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = lcgp_pkg::S_IDLE;
            end
        endcase
    end

    `LCGP_ASSERT_NEXT(a_div_to_done, i_clk, i_rst_n, r_state == lcgp_pkg::S_DIV && r_cnt == lcgp_pkg::DIV_LAST, r_state == lcgp_pkg::S_DONE)
    `LCGP_ASSERT_NEXT(a_zero_skips_div, i_clk, i_rst_n, r_state == lcgp_pkg::S_ADV && r_cnt == lcgp_pkg::ADV_LAST && i_sts.max_zero, r_state == lcgp_pkg::S_DONE)
    `LCGP_ASSERT_SAME(a_load_when_free, i_clk, i_rst_n, o_cmd.out_load, i_sts.out_free)
    `LCGP_ASSERT_SAME(a_adv_count_range, i_clk, i_rst_n, r_state == lcgp_pkg::S_ADV, r_cnt <= lcgp_pkg::ADV_LAST)

endmodule

`default_nettype wire

// ===== sv/lcg_combined_random_pick_unit.sv =====
// A request runs through three generator advances, then the one-bit-per-cycle remainder loop (32 steps)
// when the maximum is nonzero, then waits until the output register is free for the hand-off. The unit
// takes one item at a time; no new request is accepted until the previous result has been handed off.
// Reset: synchronous, active low; the generator state returns to 1 and no result is pending.
// A seed write reloads the generator state at once and is taken whenever the unit is idle.
`default_nettype none

module lcg_combined_random_pick_unit (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // Request channel.
    input  wire                          i_valid,
    output logic                         o_stall,
    input  wire  [lcgp_pkg::DATA_W-1:0]  i_modulus,
    // Result channel.
    output logic                         o_valid,
    input  wire                          i_stall,
    output logic [lcgp_pkg::DATA_W-1:0]  o_value,
    // Seed register write channel.
    input  wire                          i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire  [lcgp_pkg::DATA_W-1:0]  i_cfg_seed
);

    lcgp_pkg::t_dp_cmd w_cmd;
    lcgp_pkg::t_dp_sts w_sts;
    logic              w_idle;

    // The controller walks each item through three generator advances, an optional
    // 32-step remainder loop and a hand-off into the output register. Because the
    // result sits in its own register, the next item is taken while it waits.
    lcgp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_idle     (w_idle)
    );

    // The datapath holds the generator state, the assembled value, the divider
    // and the output register.
    lcgp_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_seed  (i_cfg_seed),
        .i_modulus   (i_modulus),
        .i_out_stall (i_stall),
        .o_out_valid (o_valid),
        .o_value     (o_value)
    );

    // A new item is taken only while the controller waits for work; a seed write is
    // accepted at the same times so that it never lands in the middle of an item.
    assign o_stall     = !w_idle;
    assign o_cfg_ready = w_idle;

endmodule

`default_nettype wire

// ===== test/tb_lcg_combined_random_pick_unit.sv =====
`timescale 1ns / 1ps

module tb_lcg_combined_random_pick_unit;

    // The generator recurrence, kept here independently of the design package
    // so that a wrong constant in the design cannot hide behind the checker.
    localparam logic [31:0] GEN_MUL = 32'd1103515245;
    localparam logic [31:0] GEN_INC = 32'd12345;
    localparam logic [31:0] GEN_RESET_STATE = 32'd1;

    // Cycles to let pass once the last result is in, a little over the
    // longest latency of the unit, which is that of a nonzero maximum.
    localparam int SETTLE_CYCLES = 45;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [31:0] i_modulus = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [31:0] o_value;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_seed = '0;

    lcg_combined_random_pick_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_modulus   (i_modulus),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_value     (o_value),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_seed  (i_cfg_seed)
    );

    always #10 i_clk = ~i_clk;

    // Maximums waiting to be sent, and the picks the unit owes us, oldest first.
    logic [31:0] pick_requests[$];
    logic [31:0] expected_picks[$];

    // Shadow of the generator state inside the unit. It moves when a request
    // is accepted and when a seed write is accepted; the two never overlap
    // because seeds are only written while the unit is drained.
    logic [31:0] gen_state = GEN_RESET_STATE;

    // Percentages of cycles in which the sender holds back and the receiver
    // stalls. The stimulus process changes them between phases only.
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    int unsigned err_count = 0;

    function automatic logic [31:0] next_gen_state(input logic [31:0] s);
        return s * GEN_MUL + GEN_INC;
    endfunction

    // Works out the pick for one request and moves the shadow state on by
    // three generator steps. Bits 18..27 of the first two steps fill the low
    // two slices; the third step contributes bits 18..29 to the top slice.
    function automatic logic [31:0] predict_pick(input logic [31:0] max_val);
        logic [31:0] s1;
        logic [31:0] s2;
        logic [31:0] s3;
        logic [31:0] raw;
        s1 = next_gen_state(gen_state);
        s2 = next_gen_state(s1);
        s3 = next_gen_state(s2);
        raw = {s3[29:18], s2[27:18], s1[27:18]};
        gen_state = s3;
        // A zero maximum means no reduction at all.
        return (max_val == 32'd0) ? raw : raw % max_val;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: %s: got 0x%08h, expected 0x%08h", $time, what, got, want);
        err_count++;
    endtask

    // Driver. The next item goes out on the same edge that accepts the current
    // one, or after an idle cycle. While the unit stalls, valid and
    // the maximum stay exactly as they are. The prediction is made at the
    // accepting edge, so the shadow state follows the order the unit sees.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                expected_picks.push_back(predict_pick(i_modulus));
            end
            if (!i_valid || !o_stall) begin
                if (pick_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_valid   <= 1'b1;
                    i_modulus <= pick_requests.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor. Every accepted result is held against the oldest expectation;
    // the stall for the following cycle is drawn afresh on every edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_picks.size() == 0) begin
                    report_mismatch("result with nothing outstanding", o_value, 32'd0);
                end else begin
                    logic [31:0] want;
                    want = expected_picks.pop_front();
                    if (o_value !== want) begin
                        report_mismatch("value", o_value, want);
                    end
                end
            end
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // A spread of maximums: zero, tiny ones where the remainder is almost
    // always taken, powers of two, values near the top of the range, and
    // plain random words so that every bit of the field toggles.
    function automatic logic [31:0] random_max();
        case ($urandom_range(9))
            0, 1:    return 32'd0;
            2:       return $urandom_range(16, 1);
            3:       return $urandom_range(1023, 1);
            4:       return 32'd1 << $urandom_range(31);
            5:       return 32'hFFFF_FFFF - $urandom_range(15);
            default: return $urandom;
        endcase
    endfunction

    // Waits until every pending item has gone in and every pick has come
    // back, then lets the unit settle before anything else is touched.
    task automatic drain();
        while (pick_requests.size() != 0 || i_valid || expected_picks.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Seed writes happen only while the unit is drained. The shadow state is
    // reloaded at the edge where valid and ready are both high.
    task automatic write_seed(input logic [31:0] seed_val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_seed  <= seed_val;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        gen_state = seed_val;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(input int unsigned n_items);
        repeat (n_items) pick_requests.push_back(random_max());
        drain();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Busy receiver, mostly eager sender. The first items run on the
        // reset seed and cover the corners of the maximum: zero, one, two,
        // all ones, the sign bit alone and its complement, and a few ordinary
        // values on both sides of the raw pick.
        send_idle_pct = 19;
        recv_idle_pct = 75;
        pick_requests = '{32'd0, 32'd1, 32'd2, 32'hFFFF_FFFF, 32'h8000_0000,
                          32'h7FFF_FFFF, 32'd0, 32'd3, 32'd10, 32'h0001_0000,
                          32'hFFFF_FFFE, 32'h0000_FFFF, 32'd0, 32'd1, 32'h5555_5555,
                          32'hAAAA_AAAA, 32'd1000, 32'h0000_0400, 32'd0, 32'd7};
        drain();

        write_seed(32'd0);
        random_phase(370);

        // Roles swapped: a sluggish sender and a receiver that rarely stalls.
        send_idle_pct = 75;
        recv_idle_pct = 19;
        write_seed(32'hFFFF_FFFF);
        random_phase(370);

        // No idling on either side, back-to-back traffic.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_seed($urandom);
        random_phase(200);
        write_seed($urandom);
        random_phase(200);

        if (err_count == 0 && expected_picks.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Safety net: the slowest correct run needs well under a tenth of this.
    initial begin
        #20_000_000;
        $display("timeout with %0d picks outstanding", expected_picks.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
